/* design/chip8_interpreter_core_assert.svh */
// Assertion macros shared by the CHIP-8 core checker.
`ifndef CHIP8_INTERPRETER_CORE_ASSERT_SVH
`define CHIP8_INTERPRETER_CORE_ASSERT_SVH

// Antecedent implies consequent in the same cycle.
`define C8IC_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("c8ic assertion failed");

// Antecedent implies consequent in the next cycle.
`define C8IC_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("c8ic assertion failed");

`endif

/* design/c8ic_pkg.sv */
// Types, constants and helper functions of the CHIP-8 core.
package c8ic_pkg;

    localparam logic [15:0] PC_START  = 16'h0200;
    localparam logic [15:0] PC_LIMIT  = 16'd4094;
    localparam logic [11:0] FONT_BASE = 12'h050;
    localparam logic [11:0] FONT_SIZE = 12'd80;

    localparam logic [15:0] OPC_CLS = 16'h00E0;
    localparam logic [15:0] OPC_RET = 16'h00EE;

    localparam logic [3:0] GRP_SYS     = 4'h0;
    localparam logic [3:0] GRP_JP      = 4'h1;
    localparam logic [3:0] GRP_CALL    = 4'h2;
    localparam logic [3:0] GRP_SE_IMM  = 4'h3;
    localparam logic [3:0] GRP_SNE_IMM = 4'h4;
    localparam logic [3:0] GRP_SE_REG  = 4'h5;
    localparam logic [3:0] GRP_LD_IMM  = 4'h6;
    localparam logic [3:0] GRP_ADD_IMM = 4'h7;
    localparam logic [3:0] GRP_ALU     = 4'h8;
    localparam logic [3:0] GRP_SNE_REG = 4'h9;
    localparam logic [3:0] GRP_LD_I    = 4'hA;
    localparam logic [3:0] GRP_JP_V0   = 4'hB;
    localparam logic [3:0] GRP_RND     = 4'hC;
    localparam logic [3:0] GRP_DRW     = 4'hD;
    localparam logic [3:0] GRP_KEY     = 4'hE;
    localparam logic [3:0] GRP_MISC    = 4'hF;

    localparam logic [3:0] ALU_MOV = 4'h0;
    localparam logic [3:0] ALU_OR  = 4'h1;
    localparam logic [3:0] ALU_AND = 4'h2;
    localparam logic [3:0] ALU_XOR = 4'h3;
    localparam logic [3:0] ALU_ADD = 4'h4;
    localparam logic [3:0] ALU_SUB = 4'h5;
    localparam logic [3:0] ALU_SHR = 4'h6;
    localparam logic [3:0] ALU_RSB = 4'h7;
    localparam logic [3:0] ALU_SHL = 4'hE;

    localparam logic [7:0] KEY_DOWN   = 8'h9E;
    localparam logic [7:0] KEY_UP     = 8'hA1;
    localparam logic [7:0] F_DELAY_RD = 8'h07;
    localparam logic [7:0] F_KEY_WAIT = 8'h0A;
    localparam logic [7:0] F_DELAY_WR = 8'h15;
    localparam logic [7:0] F_SOUND_WR = 8'h18;
    localparam logic [7:0] F_ADD_I    = 8'h1E;
    localparam logic [7:0] F_FONT     = 8'h29;
    localparam logic [7:0] F_BCD      = 8'h33;
    localparam logic [7:0] F_STORE    = 8'h55;
    localparam logic [7:0] F_LOAD     = 8'h65;

    localparam logic [7:0] FONT [80] = '{
        8'hF0, 8'h90, 8'h90, 8'h90, 8'hF0, 8'h20, 8'h60, 8'h20, 8'h20, 8'h70,
        8'hF0, 8'h10, 8'hF0, 8'h80, 8'hF0, 8'hF0, 8'h10, 8'hF0, 8'h10, 8'hF0,
        8'h90, 8'h90, 8'hF0, 8'h10, 8'h10, 8'hF0, 8'h80, 8'hF0, 8'h10, 8'hF0,
        8'hF0, 8'h80, 8'hF0, 8'h90, 8'hF0, 8'hF0, 8'h10, 8'h20, 8'h40, 8'h40,
        8'hF0, 8'h90, 8'hF0, 8'h90, 8'hF0, 8'hF0, 8'h90, 8'hF0, 8'h10, 8'hF0,
        8'hF0, 8'h90, 8'hF0, 8'h90, 8'h90, 8'hE0, 8'h90, 8'hE0, 8'h90, 8'hE0,
        8'hF0, 8'h80, 8'h80, 8'h80, 8'hF0, 8'hE0, 8'h90, 8'h90, 8'h90, 8'hE0,
        8'hF0, 8'h80, 8'hF0, 8'h80, 8'hF0, 8'hF0, 8'h80, 8'hF0, 8'h80, 8'h80
    };

    typedef enum logic [1:0] {
        OP_LOAD = 2'd0,
        OP_EXEC = 2'd1,
        OP_TICK = 2'd2,
        OP_READ = 2'd3
    } t_item_op;

    typedef enum logic [4:0] {
        ST_CLEAR, ST_IDLE, ST_LOAD, ST_TICK, ST_PIX_RD, ST_PIX_WT,
        ST_FETCH_HI, ST_FETCH_LO, ST_FETCH_LAT, ST_READ_X, ST_READ_Y, ST_EXEC,
        ST_CLS, ST_DRW_MEM, ST_DRW_FB, ST_DRW_WR, ST_DRW_END,
        ST_BCD, ST_STORE, ST_LOAD_RD, ST_LOAD_WR, ST_DONE
    } t_state;

    typedef enum logic [4:0] {
        CMD_NONE, CMD_CLEAR, CMD_LOAD, CMD_TICK, CMD_PIX_RD, CMD_PIX_WT,
        CMD_FETCH_HI, CMD_FETCH_LO, CMD_FETCH_LAT, CMD_READ_X, CMD_READ_Y, CMD_EXEC,
        CMD_CLS, CMD_DRW_MEM, CMD_DRW_FB, CMD_DRW_WR, CMD_DRW_END,
        CMD_BCD, CMD_STORE, CMD_LOAD_RD, CMD_LOAD_WR
    } t_cmd;

    typedef struct packed {
        t_cmd cmd;
        logic accept;
        logic finish;
        logic busy;
    } t_ctrl;

    typedef struct packed {
        logic [15:0] opcode;
        logic        pc_limit;
        logic        loop_last;
        logic        out_busy;
    } t_status;

    // Reset image of main memory: the glyph table at FONT_BASE, zeros elsewhere.
    function automatic logic [7:0] font_byte(input logic [11:0] addr);
        logic [11:0] off;
        off = addr - FONT_BASE;
        if (addr >= FONT_BASE && addr < FONT_BASE + FONT_SIZE) begin
            return FONT[off[6:0]];
        end
        return 8'h00;
    endfunction

endpackage

/* design/c8ic_datapath.sv */
// Datapath of the CHIP-8 core: memories, register file, stack, timers, result register.
module c8ic_datapath #(
    parameter int STACK_DEPTH = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  c8ic_pkg::t_ctrl       i_ctrl,
    output c8ic_pkg::t_status     o_status,
    input  logic [1:0]            i_operation,
    input  logic [11:0]           i_load_address,
    input  logic [7:0]            i_load_data,
    input  logic [15:0]           i_keys_down,
    input  logic [7:0]            i_random_byte,
    input  logic [5:0]            i_pixel_x,
    input  logic [4:0]            i_pixel_y,
    input  logic                  i_out_stall,
    output logic                  o_out_valid,
    output logic [15:0]           o_program_counter,
    output logic [15:0]           o_last_opcode,
    output logic                  o_pixel_value,
    output logic                  o_sound_on,
    output logic                  o_halted
);

    localparam int SP_W = $clog2(STACK_DEPTH);
    localparam logic [SP_W-1:0] SP_LAST = SP_W'(STACK_DEPTH - 1);

    // Item registers.
    logic [11:0] r_addr;
    logic [7:0]  r_data;
    logic [15:0] r_keys;
    logic [7:0]  r_rnd;
    logic [5:0]  r_px;
    logic [4:0]  r_py;

    // Architectural state.
    logic [15:0]     r_pc, n_pc;
    logic [15:0]     r_i, n_i;
    logic [15:0]     r_opcode;
    logic [SP_W-1:0] r_sp, n_sp;
    logic [7:0]      r_delay, n_delay;
    logic [7:0]      r_sound, n_sound;
    logic [15:0]     r_stack [STACK_DEPTH];
    logic [7:0]      r_v [16];

    // Sequencing state.
    logic [7:0]  r_vx, r_vy, r_hi, r_sprite;
    logic [4:0]  r_cnt, n_cnt;
    logic [11:0] r_clr;
    logic        r_coll, n_coll;
    logic        r_pixel, r_halt;

    // Memories.
    logic [7:0]  r_mem [4096];
    logic [7:0]  r_mem_q;
    logic [63:0] r_fb [32];
    logic [63:0] r_fb_q;

    logic        out_valid_q;
    logic [15:0] r_out_pc, r_out_opcode;
    logic        r_out_pixel, r_out_sound, r_out_halt;

    // Strobes.
    logic        mem_we;
    logic [11:0] mem_wa, mem_ra;
    logic [7:0]  mem_wd;
    logic        fb_we;
    logic [4:0]  fb_wa, fb_ra;
    logic [63:0] fb_wd;
    logic        stk_we;
    logic        flag_we;
    logic [7:0]  flag_wd;
    logic        vw_we;
    logic [3:0]  vw_addr;
    logic [7:0]  vw_wd;

    logic [3:0]  op_x, op_y, op_n;
    logic [7:0]  op_nn;
    logic [11:0] op_nnn;
    logic [3:0]  v_ra;
    logic [7:0]  v_rd;
    logic [SP_W-1:0] sp_inc, sp_dec;
    logic [11:0] i_off;

    logic        alu_flag_we, alu_flag;
    logic [7:0]  alu_res;
    logic [8:0]  sum9;
    logic        key_hit;
    logic [3:0]  key_idx;
    logic [63:0] mask;
    logic [1:0]  bcd_h;
    logic [6:0]  bcd_rem;
    logic [14:0] bcd_prod;
    logic [3:0]  bcd_t, bcd_o;
    logic [7:0]  bcd_digit;

    assign op_x   = r_opcode[11:8];
    assign op_y   = r_opcode[7:4];
    assign op_n   = r_opcode[3:0];
    assign op_nn  = r_opcode[7:0];
    assign op_nnn = r_opcode[11:0];

    assign sp_inc = (r_sp == SP_LAST) ? '0 : r_sp + 1'b1;
    assign sp_dec = (r_sp == '0) ? SP_LAST : r_sp - 1'b1;
    assign i_off  = r_i[11:0] + 12'(r_cnt);

    // Single read port of the register file.
    always_comb begin
        case (i_ctrl.cmd)
            c8ic_pkg::CMD_READ_Y: v_ra = op_y;
            c8ic_pkg::CMD_EXEC:   v_ra = 4'h0;
            c8ic_pkg::CMD_STORE:  v_ra = r_cnt[3:0];
            default:              v_ra = op_x;
        endcase
    end
    assign v_rd = r_v[v_ra];

    // Shifts and subtracts write VF first; their result then sees the new flag.
    always_comb begin : alu
        logic [7:0] ax, ay;
        sum9 = {1'b0, r_vx} + {1'b0, r_vy};
        case (op_n)
            c8ic_pkg::ALU_ADD: begin alu_flag_we = 1'b1; alu_flag = sum9[8];        end
            c8ic_pkg::ALU_SUB: begin alu_flag_we = 1'b1; alu_flag = r_vx >= r_vy;   end
            c8ic_pkg::ALU_SHR: begin alu_flag_we = 1'b1; alu_flag = r_vx[0];        end
            c8ic_pkg::ALU_RSB: begin alu_flag_we = 1'b1; alu_flag = r_vx <= r_vy;   end
            c8ic_pkg::ALU_SHL: begin alu_flag_we = 1'b1; alu_flag = r_vx[7];        end
            default:           begin alu_flag_we = 1'b0; alu_flag = 1'b0;           end
        endcase
        ax = (op_x == 4'hF) ? {7'b0, alu_flag} : r_vx;
        ay = (op_y == 4'hF) ? {7'b0, alu_flag} : r_vy;
        case (op_n)
            c8ic_pkg::ALU_MOV: alu_res = r_vy;
            c8ic_pkg::ALU_OR:  alu_res = r_vx | r_vy;
            c8ic_pkg::ALU_AND: alu_res = r_vx & r_vy;
            c8ic_pkg::ALU_XOR: alu_res = r_vx ^ r_vy;
            c8ic_pkg::ALU_ADD: alu_res = sum9[7:0];
            c8ic_pkg::ALU_SUB: alu_res = ax - ay;
            c8ic_pkg::ALU_SHR: alu_res = ax >> 1;
            c8ic_pkg::ALU_RSB: alu_res = ay - ax;
            c8ic_pkg::ALU_SHL: alu_res = ax << 1;
            default:           alu_res = r_vx;
        endcase
    end

    assign key_hit = (r_vx[7:4] == 4'h0) && r_keys[r_vx[3:0]];

    always_comb begin
        key_idx = 4'h0;
        for (int k = 15; k >= 0; k--) begin
            if (r_keys[k]) key_idx = 4'(k);
        end
    end

    // Sprite byte placed on its row with wrap at column 64.
    always_comb begin : draw_mask
        logic [5:0] col;
        mask = '0;
        for (int c = 0; c < 8; c++) begin
            col = r_vx[5:0] + 6'(c);
            mask[col] = r_sprite[3'(7 - c)];
        end
    end

    // Decimal digits: hundreds by compare, tens by reciprocal multiply.
    always_comb begin
        if (r_vx >= 8'd200) begin
            bcd_h = 2'd2; bcd_rem = 7'(r_vx - 8'd200);
        end else if (r_vx >= 8'd100) begin
            bcd_h = 2'd1; bcd_rem = 7'(r_vx - 8'd100);
        end else begin
            bcd_h = 2'd0; bcd_rem = r_vx[6:0];
        end
        bcd_prod = 15'(bcd_rem) * 15'd205;
        bcd_t    = bcd_prod[14:11];
        bcd_o    = 4'(bcd_rem - 7'({3'b0, bcd_t} * 7'd10));
        case (r_cnt[1:0])
            2'd0:    bcd_digit = {6'b0, bcd_h};
            2'd1:    bcd_digit = {4'b0, bcd_t};
            default: bcd_digit = {4'b0, bcd_o};
        endcase
    end

    always_comb begin
        n_pc = r_pc; n_i = r_i; n_sp = r_sp;
        n_delay = r_delay; n_sound = r_sound;
        n_cnt = r_cnt; n_coll = r_coll;
        mem_we = 1'b0; mem_wa = i_off; mem_wd = 8'h00; mem_ra = r_pc[11:0];
        fb_we = 1'b0; fb_wa = r_py; fb_wd = '0; fb_ra = r_py;
        stk_we = 1'b0;
        flag_we = 1'b0; flag_wd = 8'h00;
        vw_we = 1'b0; vw_addr = op_x; vw_wd = 8'h00;
        case (i_ctrl.cmd)
            c8ic_pkg::CMD_CLEAR: begin
                mem_we = 1'b1;
                mem_wa = r_clr;
                mem_wd = c8ic_pkg::font_byte(r_clr);
                fb_we  = (r_clr[11:5] == 7'd0);
                fb_wa  = r_clr[4:0];
            end
            c8ic_pkg::CMD_LOAD: begin
                mem_we = 1'b1; mem_wa = r_addr; mem_wd = r_data;
            end
            c8ic_pkg::CMD_TICK: begin
                if (r_delay != 8'd0) n_delay = r_delay - 8'd1;
                if (r_sound != 8'd0) n_sound = r_sound - 8'd1;
            end
            c8ic_pkg::CMD_FETCH_LO:  mem_ra = r_pc[11:0] + 12'd1;
            c8ic_pkg::CMD_FETCH_LAT: n_pc = r_pc + 16'd2;
            c8ic_pkg::CMD_EXEC: begin
                n_cnt = 5'd0;
                n_coll = 1'b0;
                case (r_opcode[15:12])
                    c8ic_pkg::GRP_SYS: begin
                        if (r_opcode == c8ic_pkg::OPC_RET) begin
                            n_sp = sp_dec;
                            n_pc = r_stack[sp_dec];
                        end
                    end
                    c8ic_pkg::GRP_JP: n_pc = {4'b0, op_nnn};
                    c8ic_pkg::GRP_CALL: begin
                        stk_we = 1'b1;
                        n_sp = sp_inc;
                        n_pc = {4'b0, op_nnn};
                    end
                    c8ic_pkg::GRP_SE_IMM:  if (r_vx == op_nn) n_pc = r_pc + 16'd2;
                    c8ic_pkg::GRP_SNE_IMM: if (r_vx != op_nn) n_pc = r_pc + 16'd2;
                    c8ic_pkg::GRP_SE_REG:  if (r_vx == r_vy)  n_pc = r_pc + 16'd2;
                    c8ic_pkg::GRP_SNE_REG: if (r_vx != r_vy)  n_pc = r_pc + 16'd2;
                    c8ic_pkg::GRP_LD_IMM: begin vw_we = 1'b1; vw_wd = op_nn; end
                    c8ic_pkg::GRP_ADD_IMM: begin vw_we = 1'b1; vw_wd = r_vx + op_nn; end
                    c8ic_pkg::GRP_ALU: begin
                        flag_we = alu_flag_we;
                        flag_wd = {7'b0, alu_flag};
                        vw_we   = (op_n inside {c8ic_pkg::ALU_MOV, c8ic_pkg::ALU_OR,
                                   c8ic_pkg::ALU_AND, c8ic_pkg::ALU_XOR}) || alu_flag_we;
                        vw_wd   = alu_res;
                    end
                    c8ic_pkg::GRP_LD_I:  n_i = {4'b0, op_nnn};
                    c8ic_pkg::GRP_JP_V0: n_pc = {8'b0, v_rd} + {4'b0, op_nnn};
                    c8ic_pkg::GRP_RND: begin vw_we = 1'b1; vw_wd = r_rnd & op_nn; end
                    c8ic_pkg::GRP_DRW: flag_we = 1'b1;
                    c8ic_pkg::GRP_KEY: begin
                        if ((op_nn == c8ic_pkg::KEY_DOWN && key_hit) ||
                            (op_nn == c8ic_pkg::KEY_UP && !key_hit)) begin
                            n_pc = r_pc + 16'd2;
                        end
                    end
                    default: begin
                        case (op_nn)
                            c8ic_pkg::F_DELAY_RD: begin vw_we = 1'b1; vw_wd = r_delay; end
                            c8ic_pkg::F_KEY_WAIT: begin
                                if (r_keys != 16'h0000) begin
                                    vw_we = 1'b1; vw_wd = {4'b0, key_idx};
                                end else begin
                                    n_pc = r_pc - 16'd2;
                                end
                            end
                            c8ic_pkg::F_DELAY_WR: n_delay = r_vx;
                            c8ic_pkg::F_SOUND_WR: n_sound = r_vx;
                            c8ic_pkg::F_ADD_I:    n_i = r_i + {8'b0, r_vx};
                            c8ic_pkg::F_FONT:
                                n_i = {4'b0, c8ic_pkg::FONT_BASE} + {6'b0, r_vx, 2'b0}
                                      + {8'b0, r_vx};
                            default: ;
                        endcase
                    end
                endcase
            end
            c8ic_pkg::CMD_CLS: begin
                fb_we = 1'b1; fb_wa = r_cnt; n_cnt = r_cnt + 5'd1;
            end
            c8ic_pkg::CMD_DRW_MEM: mem_ra = i_off;
            c8ic_pkg::CMD_DRW_FB:  fb_ra = r_vy[4:0] + r_cnt;
            c8ic_pkg::CMD_DRW_WR: begin
                fb_we  = 1'b1;
                fb_wa  = r_vy[4:0] + r_cnt;
                fb_wd  = r_fb_q ^ mask;
                n_coll = r_coll | (|(r_fb_q & mask));
                n_cnt  = r_cnt + 5'd1;
            end
            c8ic_pkg::CMD_DRW_END: begin flag_we = 1'b1; flag_wd = {7'b0, r_coll}; end
            c8ic_pkg::CMD_BCD: begin
                mem_we = 1'b1; mem_wd = bcd_digit; n_cnt = r_cnt + 5'd1;
            end
            c8ic_pkg::CMD_STORE: begin
                mem_we = 1'b1; mem_wd = v_rd; n_cnt = r_cnt + 5'd1;
            end
            c8ic_pkg::CMD_LOAD_RD: mem_ra = i_off;
            c8ic_pkg::CMD_LOAD_WR: begin
                vw_we = 1'b1; vw_addr = r_cnt[3:0]; vw_wd = r_mem_q; n_cnt = r_cnt + 5'd1;
            end
            default: ;
        endcase
    end

    always_comb begin
        o_status.opcode   = r_opcode;
        o_status.pc_limit = (r_pc >= c8ic_pkg::PC_LIMIT);
        o_status.out_busy = out_valid_q && i_out_stall;
        case (i_ctrl.cmd)
            c8ic_pkg::CMD_CLEAR:   o_status.loop_last = &r_clr;
            c8ic_pkg::CMD_CLS:     o_status.loop_last = (r_cnt == 5'd31);
            c8ic_pkg::CMD_DRW_WR:  o_status.loop_last = (r_cnt[3:0] == op_n - 4'd1);
            c8ic_pkg::CMD_BCD:     o_status.loop_last = (r_cnt == 5'd2);
            c8ic_pkg::CMD_STORE,
            c8ic_pkg::CMD_LOAD_WR: o_status.loop_last = (r_cnt[3:0] == op_x);
            default:               o_status.loop_last = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) r_mem[mem_wa] <= mem_wd;
        r_mem_q <= r_mem[mem_ra];
    end

    always_ff @(posedge i_clk) begin
        if (fb_we) r_fb[fb_wa] <= fb_wd;
        r_fb_q <= r_fb[fb_ra];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc     <= c8ic_pkg::PC_START;
            r_i      <= 16'h0000;
            r_opcode <= 16'h0000;
            r_sp     <= '0;
            r_delay  <= 8'd0;
            r_sound  <= 8'd0;
            r_clr    <= 12'd0;
            r_cnt    <= 5'd0;
            r_coll   <= 1'b0;
            r_pixel  <= 1'b0;
            r_halt   <= 1'b0;
            out_valid_q <= 1'b0;
            for (int s = 0; s < STACK_DEPTH; s++) r_stack[s] <= 16'h0000;
            for (int k = 0; k < 16; k++) r_v[k] <= 8'h00;
        end else begin
            r_pc    <= n_pc;
            r_i     <= n_i;
            r_sp    <= n_sp;
            r_delay <= n_delay;
            r_sound <= n_sound;
            r_cnt   <= n_cnt;
            r_coll  <= n_coll;
            if (i_ctrl.cmd == c8ic_pkg::CMD_CLEAR) r_clr <= r_clr + 12'd1;
            if (i_ctrl.cmd == c8ic_pkg::CMD_FETCH_LAT) r_opcode <= {r_hi, r_mem_q};
            if (i_ctrl.cmd == c8ic_pkg::CMD_PIX_WT) r_pixel <= r_fb_q[r_px];
            if (i_ctrl.accept) begin
                r_pixel <= 1'b0;
                r_halt  <= (i_operation == c8ic_pkg::OP_EXEC) &&
                           (r_pc >= c8ic_pkg::PC_LIMIT);
            end
            if (stk_we) r_stack[r_sp] <= r_pc;
            if (flag_we) r_v[15] <= flag_wd;
            if (vw_we) r_v[vw_addr] <= vw_wd;
            if (i_ctrl.finish) begin
                out_valid_q <= 1'b1;
            end else if (!i_out_stall) begin
                out_valid_q <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.accept) begin
            r_addr <= i_load_address;
            r_data <= i_load_data;
            r_keys <= i_keys_down;
            r_rnd  <= i_random_byte;
            r_px   <= i_pixel_x;
            r_py   <= i_pixel_y;
        end
        if (i_ctrl.cmd == c8ic_pkg::CMD_FETCH_LO) r_hi <= r_mem_q;
        if (i_ctrl.cmd == c8ic_pkg::CMD_READ_X) r_vx <= v_rd;
        if (i_ctrl.cmd == c8ic_pkg::CMD_READ_Y) r_vy <= v_rd;
        if (i_ctrl.cmd == c8ic_pkg::CMD_DRW_FB) r_sprite <= r_mem_q;
        if (i_ctrl.finish) begin
            r_out_pc     <= r_pc;
            r_out_opcode <= r_opcode;
            r_out_pixel  <= r_pixel;
            r_out_sound  <= (r_sound != 8'd0);
            r_out_halt   <= r_halt;
        end
    end

    assign o_out_valid       = out_valid_q;
    assign o_program_counter = r_out_pc;
    assign o_last_opcode     = r_out_opcode;
    assign o_pixel_value     = r_out_pixel;
    assign o_sound_on        = r_out_sound;
    assign o_halted          = r_out_halt;

endmodule

/* design/c8ic_controller.sv */
// Sequencer of the CHIP-8 core: walks each item through its datapath steps.
module c8ic_controller (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic [1:0]        i_operation,
    input  c8ic_pkg::t_status i_status,
    output c8ic_pkg::t_ctrl   o_ctrl
);

    c8ic_pkg::t_state r_state, n_state;

    logic [3:0] grp;
    logic [7:0] low;

    assign grp = i_status.opcode[15:12];
    assign low = i_status.opcode[7:0];

    always_comb begin
        n_state = r_state;
        case (r_state)
            c8ic_pkg::ST_CLEAR: if (i_status.loop_last) n_state = c8ic_pkg::ST_IDLE;
            c8ic_pkg::ST_IDLE: begin
                if (i_in_valid) begin
                    case (i_operation)
                        c8ic_pkg::OP_LOAD: n_state = c8ic_pkg::ST_LOAD;
                        c8ic_pkg::OP_EXEC: n_state = i_status.pc_limit ? c8ic_pkg::ST_DONE
                                                                       : c8ic_pkg::ST_FETCH_HI;
                        c8ic_pkg::OP_TICK: n_state = c8ic_pkg::ST_TICK;
                        default:           n_state = c8ic_pkg::ST_PIX_RD;
                    endcase
                end
            end
            c8ic_pkg::ST_LOAD, c8ic_pkg::ST_TICK, c8ic_pkg::ST_PIX_WT,
            c8ic_pkg::ST_DRW_END:   n_state = c8ic_pkg::ST_DONE;
            c8ic_pkg::ST_PIX_RD:    n_state = c8ic_pkg::ST_PIX_WT;
            c8ic_pkg::ST_FETCH_HI:  n_state = c8ic_pkg::ST_FETCH_LO;
            c8ic_pkg::ST_FETCH_LO:  n_state = c8ic_pkg::ST_FETCH_LAT;
            c8ic_pkg::ST_FETCH_LAT: n_state = c8ic_pkg::ST_READ_X;
            c8ic_pkg::ST_READ_X:    n_state = c8ic_pkg::ST_READ_Y;
            c8ic_pkg::ST_READ_Y:    n_state = c8ic_pkg::ST_EXEC;
            c8ic_pkg::ST_EXEC: begin
                n_state = c8ic_pkg::ST_DONE;
                if (i_status.opcode == c8ic_pkg::OPC_CLS) begin
                    n_state = c8ic_pkg::ST_CLS;
                end else if (grp == c8ic_pkg::GRP_DRW) begin
                    // A zero-height sprite only clears the flag.
                    if (i_status.opcode[3:0] != 4'h0) n_state = c8ic_pkg::ST_DRW_MEM;
                end else if (grp == c8ic_pkg::GRP_MISC) begin
                    case (low)
                        c8ic_pkg::F_BCD:   n_state = c8ic_pkg::ST_BCD;
                        c8ic_pkg::F_STORE: n_state = c8ic_pkg::ST_STORE;
                        c8ic_pkg::F_LOAD:  n_state = c8ic_pkg::ST_LOAD_RD;
                        default:           n_state = c8ic_pkg::ST_DONE;
                    endcase
                end
            end
            c8ic_pkg::ST_CLS, c8ic_pkg::ST_BCD, c8ic_pkg::ST_STORE:
                if (i_status.loop_last) n_state = c8ic_pkg::ST_DONE;
            c8ic_pkg::ST_DRW_MEM: n_state = c8ic_pkg::ST_DRW_FB;
            c8ic_pkg::ST_DRW_FB:  n_state = c8ic_pkg::ST_DRW_WR;
            c8ic_pkg::ST_DRW_WR:  n_state = i_status.loop_last ? c8ic_pkg::ST_DRW_END
                                                               : c8ic_pkg::ST_DRW_MEM;
            c8ic_pkg::ST_LOAD_RD: n_state = c8ic_pkg::ST_LOAD_WR;
            c8ic_pkg::ST_LOAD_WR: n_state = i_status.loop_last ? c8ic_pkg::ST_DONE
                                                               : c8ic_pkg::ST_LOAD_RD;
            c8ic_pkg::ST_DONE: if (!i_status.out_busy) n_state = c8ic_pkg::ST_IDLE;
            default: n_state = c8ic_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        o_ctrl.accept = (r_state == c8ic_pkg::ST_IDLE) && i_in_valid;
        o_ctrl.finish = (r_state == c8ic_pkg::ST_DONE) && !i_status.out_busy;
        o_ctrl.busy   = (r_state != c8ic_pkg::ST_IDLE);
        case (r_state)
            c8ic_pkg::ST_CLEAR:     o_ctrl.cmd = c8ic_pkg::CMD_CLEAR;
            c8ic_pkg::ST_LOAD:      o_ctrl.cmd = c8ic_pkg::CMD_LOAD;
            c8ic_pkg::ST_TICK:      o_ctrl.cmd = c8ic_pkg::CMD_TICK;
            c8ic_pkg::ST_PIX_RD:    o_ctrl.cmd = c8ic_pkg::CMD_PIX_RD;
            c8ic_pkg::ST_PIX_WT:    o_ctrl.cmd = c8ic_pkg::CMD_PIX_WT;
            c8ic_pkg::ST_FETCH_HI:  o_ctrl.cmd = c8ic_pkg::CMD_FETCH_HI;
            c8ic_pkg::ST_FETCH_LO:  o_ctrl.cmd = c8ic_pkg::CMD_FETCH_LO;
            c8ic_pkg::ST_FETCH_LAT: o_ctrl.cmd = c8ic_pkg::CMD_FETCH_LAT;
            c8ic_pkg::ST_READ_X:    o_ctrl.cmd = c8ic_pkg::CMD_READ_X;
            c8ic_pkg::ST_READ_Y:    o_ctrl.cmd = c8ic_pkg::CMD_READ_Y;
            c8ic_pkg::ST_EXEC:      o_ctrl.cmd = c8ic_pkg::CMD_EXEC;
            c8ic_pkg::ST_CLS:       o_ctrl.cmd = c8ic_pkg::CMD_CLS;
            c8ic_pkg::ST_DRW_MEM:   o_ctrl.cmd = c8ic_pkg::CMD_DRW_MEM;
            c8ic_pkg::ST_DRW_FB:    o_ctrl.cmd = c8ic_pkg::CMD_DRW_FB;
            c8ic_pkg::ST_DRW_WR:    o_ctrl.cmd = c8ic_pkg::CMD_DRW_WR;
            c8ic_pkg::ST_DRW_END:   o_ctrl.cmd = c8ic_pkg::CMD_DRW_END;
            c8ic_pkg::ST_BCD:       o_ctrl.cmd = c8ic_pkg::CMD_BCD;
            c8ic_pkg::ST_STORE:     o_ctrl.cmd = c8ic_pkg::CMD_STORE;
            c8ic_pkg::ST_LOAD_RD:   o_ctrl.cmd = c8ic_pkg::CMD_LOAD_RD;
            c8ic_pkg::ST_LOAD_WR:   o_ctrl.cmd = c8ic_pkg::CMD_LOAD_WR;
            default:                o_ctrl.cmd = c8ic_pkg::CMD_NONE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= c8ic_pkg::ST_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

/* design/chip8_interpreter_core.sv */
// Steps: load and tick one state each; pixel read reads, then latches the frame buffer row;
// execute fetches both opcode bytes, reads VX and VY, then executes; draw then reads memory,
// reads and writes back the frame buffer per sprite row, then sets the flag; clear screen
// writes all 32 rows, FX33 three digits, FX55 V0..VX, FX65 reads then writes each of V0..VX.
// One item is in work at a time; the next transfer is taken once the result is registered.
// After reset a clearing pass loads the font and clears the screen; no item is taken during it.
module chip8_interpreter_core #(
    parameter int STACK_DEPTH = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [1:0]  i_operation,
    input  logic [11:0] i_load_address,
    input  logic [7:0]  i_load_data,
    input  logic [15:0] i_keys_down,
    input  logic [7:0]  i_random_byte,
    input  logic [5:0]  i_pixel_x,
    input  logic [4:0]  i_pixel_y,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [15:0] o_program_counter,
    output logic [15:0] o_last_opcode,
    output logic        o_pixel_value,
    output logic        o_sound_on,
    output logic        o_halted
);

    c8ic_pkg::t_ctrl   ctrl;
    c8ic_pkg::t_status status;

    c8ic_controller u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_operation (i_operation),
        .i_status    (status),
        .o_ctrl      (ctrl)
    );

    c8ic_datapath #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_ctrl            (ctrl),
        .o_status          (status),
        .i_operation       (i_operation),
        .i_load_address    (i_load_address),
        .i_load_data       (i_load_data),
        .i_keys_down       (i_keys_down),
        .i_random_byte     (i_random_byte),
        .i_pixel_x         (i_pixel_x),
        .i_pixel_y         (i_pixel_y),
        .i_out_stall       (i_out_stall),
        .o_out_valid       (o_out_valid),
        .o_program_counter (o_program_counter),
        .o_last_opcode     (o_last_opcode),
        .o_pixel_value     (o_pixel_value),
        .o_sound_on        (o_sound_on),
        .o_halted          (o_halted)
    );

    assign o_in_stall = ctrl.busy;

endmodule

/* design/c8ic_checker.sv */
// Port-level checker of the CHIP-8 core and its bind to the top level.
`include "chip8_interpreter_core_assert.svh"

module c8ic_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        o_in_stall,
    input logic        o_out_valid,
    input logic        i_out_stall,
    input logic [15:0] o_program_counter,
    input logic [15:0] o_last_opcode,
    input logic        o_pixel_value,
    input logic        o_halted
);

    // A stalled result holds.
    `C8IC_ASSERT_NXT(a_out_hold, o_out_valid && i_out_stall, o_out_valid && $stable(o_program_counter) && $stable(o_last_opcode))

    // A halted result only comes from a counter at the limit and never carries a pixel.
    `C8IC_ASSERT_IMP(a_halt_pc, o_out_valid && o_halted, (o_program_counter >= 16'd4094) && !o_pixel_value)

    // The core works on one item at a time.
    `C8IC_ASSERT_NXT(a_busy_after_transfer, i_in_valid && !o_in_stall, o_in_stall)

endmodule

bind chip8_interpreter_core c8ic_checker u_c8ic_checker (.*);

/* bench/tb_chip8_interpreter_core.sv */
// Self-checking testbench for the CHIP-8 core: directed table, then random programs.
module tb_chip8_interpreter_core;

    typedef struct {
        c8ic_pkg::t_item_op op;
        logic [11:0] addr;
        logic [7:0]  data;
        logic [15:0] keys;
        logic [7:0]  rnd;
        logic [5:0]  px;
        logic [4:0]  py;
    } t_item;

    typedef struct {
        logic [15:0] pc;
        logic [15:0] opcode;
        logic        pixel;
        logic        sound;
        logic        halted;
    } t_result;

    typedef struct {
        t_item   it;
        bit      known;
        t_result want;
    } t_row;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_stall;
    logic [1:0]  i_operation;
    logic [11:0] i_load_address;
    logic [7:0]  i_load_data;
    logic [15:0] i_keys_down;
    logic [7:0]  i_random_byte;
    logic [5:0]  i_pixel_x;
    logic [4:0]  i_pixel_y;
    logic        o_out_valid;
    logic        i_out_stall;
    logic [15:0] o_program_counter;
    logic [15:0] o_last_opcode;
    logic        o_pixel_value;
    logic        o_sound_on;
    logic        o_halted;

    chip8_interpreter_core DUT (.*);

    // Shadow copy of the machine state.
    logic [7:0]  mem [4096];
    logic [7:0]  vreg [16];
    logic [15:0] ret_stack [16];
    logic [3:0]  sp;
    logic [15:0] pc;
    logic [15:0] index_reg;
    logic [15:0] opc;
    logic [7:0]  delay_cnt;
    logic [7:0]  sound_cnt;
    logic        screen [2048];

    t_result results_due [$];
    t_row    directed [$];
    int      items_sent;
    int      mismatches;
    bit      quiet_in;

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    initial begin
        #5_000_000;
        $display("chip8_interpreter_core regression: fail");
        $finish;
    end

    function automatic bit key_down(logic [15:0] keys, logic [7:0] k);
        return k < 8'd16 && keys[k[3:0]];
    endfunction

    task automatic run_instruction(input logic [15:0] keys, input logic [7:0] rnd);
        logic [15:0] op;
        logic [3:0]  x, y, n;
        logic [7:0]  nn, vx, vy, bits;
        logic [11:0] nnn;
        logic [8:0]  sum;
        logic [4:0]  row_y;
        logic [5:0]  col_x;
        logic        old_px, found;
        op = {mem[pc[11:0]], mem[12'(pc + 16'd1)]};
        opc = op;
        pc = pc + 16'd2;
        x = op[11:8];
        y = op[7:4];
        n = op[3:0];
        nn = op[7:0];
        nnn = op[11:0];
        case (op[15:12])
            c8ic_pkg::GRP_SYS: begin
                if (op == c8ic_pkg::OPC_CLS) begin
                    foreach (screen[i]) screen[i] = 1'b0;
                end else if (op == c8ic_pkg::OPC_RET) begin
                    sp = sp - 4'd1;
                    pc = ret_stack[sp];
                end
            end
            c8ic_pkg::GRP_JP: pc = {4'h0, nnn};
            c8ic_pkg::GRP_CALL: begin
                ret_stack[sp] = pc;
                sp = sp + 4'd1;
                pc = {4'h0, nnn};
            end
            c8ic_pkg::GRP_SE_IMM: if (vreg[x] == nn) pc = pc + 16'd2;
            c8ic_pkg::GRP_SNE_IMM: if (vreg[x] != nn) pc = pc + 16'd2;
            c8ic_pkg::GRP_SE_REG: if (vreg[x] == vreg[y]) pc = pc + 16'd2;
            c8ic_pkg::GRP_LD_IMM: vreg[x] = nn;
            c8ic_pkg::GRP_ADD_IMM: vreg[x] = vreg[x] + nn;
            c8ic_pkg::GRP_ALU: begin
                // The flag is written first; the result then uses registers as they stand.
                case (n)
                    c8ic_pkg::ALU_MOV: vreg[x] = vreg[y];
                    c8ic_pkg::ALU_OR:  vreg[x] = vreg[x] | vreg[y];
                    c8ic_pkg::ALU_AND: vreg[x] = vreg[x] & vreg[y];
                    c8ic_pkg::ALU_XOR: vreg[x] = vreg[x] ^ vreg[y];
                    c8ic_pkg::ALU_ADD: begin
                        // The sum is taken before the flag is written.
                        sum = {1'b0, vreg[x]} + {1'b0, vreg[y]};
                        vreg[15] = {7'd0, sum[8]};
                        vreg[x] = sum[7:0];
                    end
                    c8ic_pkg::ALU_SUB: begin
                        vreg[15] = {7'd0, vreg[x] >= vreg[y]};
                        vreg[x] = vreg[x] - vreg[y];
                    end
                    c8ic_pkg::ALU_SHR: begin
                        vreg[15] = {7'd0, vreg[x][0]};
                        vreg[x] = vreg[x] >> 1;
                    end
                    c8ic_pkg::ALU_RSB: begin
                        vreg[15] = {7'd0, vreg[x] <= vreg[y]};
                        vreg[x] = vreg[y] - vreg[x];
                    end
                    c8ic_pkg::ALU_SHL: begin
                        vreg[15] = {7'd0, vreg[x][7]};
                        vreg[x] = vreg[x] << 1;
                    end
                    default: ;
                endcase
            end
            c8ic_pkg::GRP_SNE_REG: if (vreg[x] != vreg[y]) pc = pc + 16'd2;
            c8ic_pkg::GRP_LD_I: index_reg = {4'h0, nnn};
            c8ic_pkg::GRP_JP_V0: pc = {8'h00, vreg[0]} + {4'h0, nnn};
            c8ic_pkg::GRP_RND: vreg[x] = rnd & nn;
            c8ic_pkg::GRP_DRW: begin
                vx = vreg[x];
                vy = vreg[y];
                vreg[15] = 8'd0;
                for (int r = 0; r < n; r++) begin
                    bits = mem[12'(index_reg + 16'(r))];
                    row_y = 5'(vy + 8'(r));
                    for (int c = 0; c < 8; c++) begin
                        col_x = 6'(vx + 8'(c));
                        old_px = screen[{row_y, col_x}];
                        screen[{row_y, col_x}] = old_px ^ bits[7 - c];
                        if (old_px && !screen[{row_y, col_x}]) vreg[15] = 8'd1;
                    end
                end
            end
            c8ic_pkg::GRP_KEY: begin
                if (nn == c8ic_pkg::KEY_DOWN && key_down(keys, vreg[x])) pc = pc + 16'd2;
                else if (nn == c8ic_pkg::KEY_UP && !key_down(keys, vreg[x])) pc = pc + 16'd2;
            end
            default: begin
                case (nn)
                    c8ic_pkg::F_DELAY_RD: vreg[x] = delay_cnt;
                    c8ic_pkg::F_KEY_WAIT: begin
                        found = 1'b0;
                        for (int k = 0; k < 16; k++) begin
                            if (!found && keys[k]) begin
                                vreg[x] = 8'(k);
                                found = 1'b1;
                            end
                        end
                        if (!found) pc = pc - 16'd2;
                    end
                    c8ic_pkg::F_DELAY_WR: delay_cnt = vreg[x];
                    c8ic_pkg::F_SOUND_WR: sound_cnt = vreg[x];
                    c8ic_pkg::F_ADD_I: index_reg = index_reg + {8'h00, vreg[x]};
                    c8ic_pkg::F_FONT:
                        index_reg = {4'h0, c8ic_pkg::FONT_BASE} + 16'(vreg[x]) * 16'd5;
                    c8ic_pkg::F_BCD: begin
                        mem[index_reg[11:0]] = vreg[x] / 8'd100;
                        mem[12'(index_reg + 16'd1)] = (vreg[x] / 8'd10) % 8'd10;
                        mem[12'(index_reg + 16'd2)] = vreg[x] % 8'd10;
                    end
                    c8ic_pkg::F_STORE:
                        for (int i = 0; i <= x; i++) mem[12'(index_reg + 16'(i))] = vreg[i];
                    c8ic_pkg::F_LOAD:
                        for (int i = 0; i <= x; i++) vreg[i] = mem[12'(index_reg + 16'(i))];
                    default: ;
                endcase
            end
        endcase
    endtask

    task automatic predict_item(input t_item it, output t_result r);
        r = '{default: '0};
        case (it.op)
            c8ic_pkg::OP_LOAD: mem[it.addr] = it.data;
            c8ic_pkg::OP_EXEC: begin
                if (pc >= c8ic_pkg::PC_LIMIT) r.halted = 1'b1;
                else run_instruction(it.keys, it.rnd);
            end
            c8ic_pkg::OP_TICK: begin
                if (delay_cnt != 8'd0) delay_cnt = delay_cnt - 8'd1;
                if (sound_cnt != 8'd0) sound_cnt = sound_cnt - 8'd1;
            end
            default: r.pixel = screen[{it.py, it.px}];
        endcase
        r.pc = pc;
        r.opcode = opc;
        r.sound = sound_cnt != 8'd0;
    endtask

    function automatic t_item make_item(c8ic_pkg::t_item_op op, logic [11:0] addr,
                                        logic [7:0] data, logic [15:0] keys,
                                        logic [5:0] px, logic [4:0] py);
        t_item it;
        it.op = op;
        it.addr = addr;
        it.data = data;
        it.keys = keys;
        it.rnd = 8'($urandom);
        it.px = px;
        it.py = py;
        return it;
    endfunction

    function automatic logic [15:0] random_keys();
        int r;
        r = $urandom_range(0, 99);
        if (r < 25) return 16'h0000;
        if (r < 35) return 16'hFFFF;
        if (r < 55) return 16'h0001 << $urandom_range(0, 15);
        return 16'($urandom);
    endfunction

    // Random instruction with every group and sub-operation reachable, targets kept low.
    function automatic logic [15:0] random_opcode(logic [15:0] at_pc);
        logic [3:0]  grp, x, y;
        logic [7:0]  f_codes [10];
        logic [3:0]  alu_codes [10];
        grp = 4'($urandom);
        x = 4'($urandom);
        y = 4'($urandom);
        f_codes = '{c8ic_pkg::F_DELAY_RD, c8ic_pkg::F_KEY_WAIT, c8ic_pkg::F_DELAY_WR,
                    c8ic_pkg::F_SOUND_WR, c8ic_pkg::F_ADD_I, c8ic_pkg::F_FONT,
                    c8ic_pkg::F_BCD, c8ic_pkg::F_STORE, c8ic_pkg::F_LOAD, 8'($urandom)};
        alu_codes = '{c8ic_pkg::ALU_MOV, c8ic_pkg::ALU_OR, c8ic_pkg::ALU_AND,
                      c8ic_pkg::ALU_XOR, c8ic_pkg::ALU_ADD, c8ic_pkg::ALU_SUB,
                      c8ic_pkg::ALU_SHR, c8ic_pkg::ALU_RSB, c8ic_pkg::ALU_SHL,
                      4'($urandom)};
        if (at_pc >= 16'h0E00) return {c8ic_pkg::GRP_JP, 12'($urandom_range(0, 12'h7FF))};
        case (grp)
            c8ic_pkg::GRP_SYS: begin
                case ($urandom_range(0, 2))
                    0: return c8ic_pkg::OPC_CLS;
                    1: return c8ic_pkg::OPC_RET;
                    default: return {c8ic_pkg::GRP_SYS, 12'($urandom)};
                endcase
            end
            c8ic_pkg::GRP_JP, c8ic_pkg::GRP_CALL:
                return {grp, 12'($urandom_range(0, 12'hEFF))};
            c8ic_pkg::GRP_JP_V0: return {grp, 12'($urandom_range(0, 12'hDFF))};
            c8ic_pkg::GRP_ALU: return {grp, x, y, alu_codes[$urandom_range(0, 9)]};
            c8ic_pkg::GRP_KEY: begin
                case ($urandom_range(0, 2))
                    0: return {grp, x, c8ic_pkg::KEY_DOWN};
                    1: return {grp, x, c8ic_pkg::KEY_UP};
                    default: return {grp, x, 8'($urandom)};
                endcase
            end
            c8ic_pkg::GRP_MISC: return {grp, x, f_codes[$urandom_range(0, 9)]};
            default: return {grp, 12'($urandom)};
        endcase
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (quiet_in || r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    task automatic send(input t_item it, input bit known, input t_result want);
        t_result predicted;
        int gap;
        @(negedge i_clk);
        i_in_valid = 1'b1;
        i_operation = it.op;
        i_load_address = it.addr;
        i_load_data = it.data;
        i_keys_down = it.keys;
        i_random_byte = it.rnd;
        i_pixel_x = it.px;
        i_pixel_y = it.py;
        do @(posedge i_clk); while (o_in_stall);
        predict_item(it, predicted);
        results_due.push_back(known ? want : predicted);
        items_sent++;
        gap = pick_gap();
        if (gap > 0) begin
            @(negedge i_clk);
            i_in_valid = 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
    endtask

    // Writes one instruction at the predicted counter and executes it.
    task automatic send_instruction(input logic [15:0] op, input logic [15:0] keys);
        t_result none;
        none = '{default: '0};
        send(make_item(c8ic_pkg::OP_LOAD, pc[11:0], op[15:8], keys, 6'd0, 5'd0), 1'b0, none);
        send(make_item(c8ic_pkg::OP_LOAD, 12'(pc + 16'd1), op[7:0], keys, 6'd0, 5'd0),
             1'b0, none);
        send(make_item(c8ic_pkg::OP_EXEC, 12'($urandom), 8'($urandom), keys, 6'($urandom),
                       5'($urandom)), 1'b0, none);
    endtask

    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (results_due.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("result with none expected: pc %h", o_program_counter);
            end else begin
                want = results_due.pop_front();
                if (o_program_counter !== want.pc || o_last_opcode !== want.opcode ||
                    o_pixel_value !== want.pixel || o_sound_on !== want.sound ||
                    o_halted !== want.halted) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected pc %h op %h pix %b snd %b halt %b, got %h %h %b %b %b",
                                 want.pc, want.opcode, want.pixel, want.sound, want.halted,
                                 o_program_counter, o_last_opcode, o_pixel_value, o_sound_on,
                                 o_halted);
                end
            end
        end
    end

    // Receiver side: random stalls, quiet stretches, and one long hold-off to back up the block.
    initial begin
        bit held;
        int r;
        held = 1'b0;
        i_out_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (!held && items_sent >= 150) begin
                held = 1'b1;
                i_out_stall = 1'b1;
                repeat (400) @(negedge i_clk);
            end
            r = $urandom_range(0, 99);
            if ((items_sent / 100) % 3 == 1 || r < 70) begin
                i_out_stall = 1'b0;
            end else begin
                i_out_stall = 1'b1;
                repeat (r < 95 ? $urandom_range(0, 3) : $urandom_range(10, 40)) @(negedge i_clk);
            end
        end
    end

    initial begin
        t_result none, base;
        t_item   it;
        int      r;
        none = '{default: '0};
        items_sent = 0;
        mismatches = 0;
        quiet_in = 1'b0;
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_operation = c8ic_pkg::OP_LOAD;
        i_load_address = '0;
        i_load_data = '0;
        i_keys_down = '0;
        i_random_byte = '0;
        i_pixel_x = '0;
        i_pixel_y = '0;
        foreach (mem[i]) mem[i] = 8'h00;
        for (int i = 0; i < int'(c8ic_pkg::FONT_SIZE); i++)
            mem[c8ic_pkg::FONT_BASE + 12'(i)] = c8ic_pkg::FONT[i];
        foreach (vreg[i]) vreg[i] = 8'h00;
        foreach (ret_stack[i]) ret_stack[i] = 16'h0000;
        foreach (screen[i]) screen[i] = 1'b0;
        sp = '0;
        pc = c8ic_pkg::PC_START;
        index_reg = '0;
        opc = '0;
        delay_cnt = '0;
        sound_cnt = '0;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        base = '{pc: c8ic_pkg::PC_START, default: '0};
        directed = '{
            '{make_item(c8ic_pkg::OP_READ, 12'h000, 8'h00, 16'h0000, 6'd0, 5'd0), 1'b1, base},
            '{make_item(c8ic_pkg::OP_READ, 12'hFFF, 8'hFF, 16'hFFFF, 6'd63, 5'd31), 1'b1, base},
            '{make_item(c8ic_pkg::OP_TICK, 12'h000, 8'h00, 16'h0000, 6'd0, 5'd0), 1'b1, base},
            // Empty memory decodes as an unknown system call: only the counter moves.
            '{make_item(c8ic_pkg::OP_EXEC, 12'h000, 8'h00, 16'h0000, 6'd0, 5'd0), 1'b1,
              '{pc: 16'h0202, default: '0}},
            '{make_item(c8ic_pkg::OP_LOAD, 12'hFFF, 8'hFF, 16'h0000, 6'd0, 5'd0), 1'b1,
              '{pc: 16'h0202, default: '0}},
            '{make_item(c8ic_pkg::OP_LOAD, 12'h000, 8'h00, 16'h0000, 6'd0, 5'd0), 1'b1,
              '{pc: 16'h0202, default: '0}},
            '{make_item(c8ic_pkg::OP_LOAD, 12'h202, 8'h60, 16'h0000, 6'd0, 5'd0), 1'b0, none},
            '{make_item(c8ic_pkg::OP_LOAD, 12'h203, 8'hFF, 16'h0000, 6'd0, 5'd0), 1'b0, none},
            '{make_item(c8ic_pkg::OP_EXEC, 12'h000, 8'h00, 16'hFFFF, 6'd0, 5'd0), 1'b0, none},
            '{make_item(c8ic_pkg::OP_LOAD, 12'h204, 8'hF0, 16'h0000, 6'd0, 5'd0), 1'b0, none},
            '{make_item(c8ic_pkg::OP_LOAD, 12'h205, 8'h18, 16'h0000, 6'd0, 5'd0), 1'b0, none},
            '{make_item(c8ic_pkg::OP_EXEC, 12'h000, 8'h00, 16'h0000, 6'd0, 5'd0), 1'b0, none},
            '{make_item(c8ic_pkg::OP_LOAD, 12'h206, 8'hA0, 16'h0000, 6'd0, 5'd0), 1'b0, none},
            '{make_item(c8ic_pkg::OP_LOAD, 12'h207, 8'h50, 16'h0000, 6'd0, 5'd0), 1'b0, none},
            '{make_item(c8ic_pkg::OP_EXEC, 12'h000, 8'h00, 16'h0000, 6'd0, 5'd0), 1'b0, none},
            // Fifteen-row sprite at the far corner wraps on both axes.
            '{make_item(c8ic_pkg::OP_LOAD, 12'h208, 8'hD0, 16'h0000, 6'd0, 5'd0), 1'b0, none},
            '{make_item(c8ic_pkg::OP_LOAD, 12'h209, 8'h0F, 16'h0000, 6'd0, 5'd0), 1'b0, none},
            '{make_item(c8ic_pkg::OP_EXEC, 12'h000, 8'h00, 16'h0000, 6'd0, 5'd0), 1'b0, none},
            '{make_item(c8ic_pkg::OP_READ, 12'h000, 8'h00, 16'h0000, 6'd63, 5'd31), 1'b0, none},
            '{make_item(c8ic_pkg::OP_READ, 12'h000, 8'h00, 16'h0000, 6'd0, 5'd0), 1'b0, none},
            '{make_item(c8ic_pkg::OP_TICK, 12'h000, 8'h00, 16'h0000, 6'd0, 5'd0), 1'b0, none},
            // Key wait with nothing pressed runs again; then the highest key alone.
            '{make_item(c8ic_pkg::OP_LOAD, 12'h20A, 8'hF0, 16'h0000, 6'd0, 5'd0), 1'b0, none},
            '{make_item(c8ic_pkg::OP_LOAD, 12'h20B, 8'h0A, 16'h0000, 6'd0, 5'd0), 1'b0, none},
            '{make_item(c8ic_pkg::OP_EXEC, 12'h000, 8'h00, 16'h0000, 6'd0, 5'd0), 1'b0, none},
            '{make_item(c8ic_pkg::OP_EXEC, 12'h000, 8'h00, 16'h8000, 6'd0, 5'd0), 1'b0, none}
        };
        foreach (directed[i]) send(directed[i].it, directed[i].known, directed[i].want);

        while (items_sent < 540) begin
            quiet_in = (items_sent / 80) % 4 == 2;
            r = $urandom_range(0, 99);
            it = make_item(c8ic_pkg::t_item_op'($urandom_range(0, 3)), 12'($urandom),
                           8'($urandom), random_keys(), 6'($urandom), 5'($urandom));
            if (r < 65) begin
                send_instruction(random_opcode(pc), random_keys());
            end else if (r < 70) begin
                it.op = c8ic_pkg::OP_EXEC;
                send(it, 1'b0, none);
            end else if (r < 80) begin
                it.op = c8ic_pkg::OP_TICK;
                send(it, 1'b0, none);
            end else if (r < 92) begin
                it.op = c8ic_pkg::OP_READ;
                send(it, 1'b0, none);
            end else begin
                it.op = c8ic_pkg::OP_LOAD;
                send(it, 1'b0, none);
            end
        end

        // Jump to the last word so that further execute items are ignored.
        send_instruction({c8ic_pkg::GRP_JP, 12'hFFE}, 16'h0000);
        repeat (3) send(make_item(c8ic_pkg::OP_EXEC, 12'h000, 8'h00, random_keys(), 6'd0, 5'd0),
                        1'b0, none);

        @(negedge i_clk);
        i_in_valid = 1'b0;
        while (results_due.size() != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
        if (mismatches == 0 && results_due.size() == 0) begin
            $display("chip8_interpreter_core regression: pass");
        end else begin
            $display("chip8_interpreter_core regression: fail");
        end
        $finish;
    end

endmodule
